[design/ibp_pkg.sv]
// ----------------------------------------------------------------------------
// ibp_pkg
// Shared types and constants for the instruction bundle packer.
// ----------------------------------------------------------------------------
package ibp_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned ReuseW    = 4;
  localparam int unsigned Slots     = 3;
  localparam int unsigned SlotBits  = 21;
  localparam int unsigned ReuseShift = 17;

  localparam logic [SlotBits-1:0] SlotBase = 21'h0007E0;
  localparam logic [WordW-1:0]    NopWord  = 64'h50B0000000070F00;

  // One closed bundle: instructions in arrival order, count is 1..3
  typedef struct packed {
    logic [Slots-1:0][WordW-1:0]  words;
    logic [Slots-1:0][ReuseW-1:0] reuse;
    logic [1:0]                   count;
    logic                         prog_end;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } bundle_req_t;

endpackage

[design/ibp_front.sv]
// ----------------------------------------------------------------------------
// ibp_front
// Accepts instructions, holds up to two, and closes a bundle on the third
// instruction or on the last instruction of a program.
// ----------------------------------------------------------------------------
module ibp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ibp_pkg::WordW-1:0]   instr_word_i,
  input  logic [ibp_pkg::ReuseW-1:0]  instr_reuse_i,
  input  logic                        is_last_i,
  input  logic                        q_full_i,
  output ibp_pkg::bundle_req_t        push_o
);
  import ibp_pkg::*;

  logic [WordW-1:0]  held_words_q [2];
  logic [ReuseW-1:0] held_reuse_q [2];
  logic [1:0]        count_q, count_d;
  logic              accept;
  logic              closes;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign closes     = is_last_i | (count_q == 2'd2);

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = closes ? 2'd0 : count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !closes) begin
      held_words_q[count_q[0]] <= instr_word_i;
      held_reuse_q[count_q[0]] <= instr_reuse_i;
    end
  end

  // Slot i takes a held entry below count, the incoming one at count
  always_comb begin
    push_o.valid         = accept & closes;
    push_o.data.count    = count_q + 2'd1;
    push_o.data.prog_end = is_last_i;
    push_o.data.words[2] = instr_word_i;
    push_o.data.reuse[2] = instr_reuse_i;
    push_o.data.words[1] = (count_q == 2'd2) ? held_words_q[1] : instr_word_i;
    push_o.data.reuse[1] = (count_q == 2'd2) ? held_reuse_q[1] : instr_reuse_i;
    push_o.data.words[0] = (count_q != 2'd0) ? held_words_q[0] : instr_word_i;
    push_o.data.reuse[0] = (count_q != 2'd0) ? held_reuse_q[0] : instr_reuse_i;
  end

endmodule

[design/ibp_queue.sv]
// ----------------------------------------------------------------------------
// ibp_queue
// Two-entry bundle queue between the front and back parts.
// ----------------------------------------------------------------------------
module ibp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ibp_pkg::bundle_req_t push_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output ibp_pkg::bundle_t     head_o
);
  import ibp_pkg::*;

  bundle_t    entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

[design/ibp_back.sv]
// ----------------------------------------------------------------------------
// ibp_back
// Streams the head bundle as four words: control word, instructions, NOPs.
// ----------------------------------------------------------------------------
module ibp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  ibp_pkg::bundle_t          head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ibp_pkg::WordW-1:0] out_word_o,
  output logic                      out_last_o,
  output logic                      program_end_o
);
  import ibp_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic               accept;
  logic [WordW-1:0]   ctrl;
  logic [SlotBits-1:0] field [Slots];

  assign out_valid_o = ~empty_i;
  assign accept      = out_valid_o & out_ready_i;
  assign out_last_o  = (idx_q == 2'd3);
  assign program_end_o = out_last_o & head_i.prog_end;
  assign pop_o       = accept & out_last_o;

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      field[i] = SlotBase;
      if (i < int'(head_i.count)) begin
        field[i] = SlotBase | {head_i.reuse[i], {ReuseShift{1'b0}}};
      end
    end
    ctrl = {1'b0, field[2], field[1], field[0]};
  end

  always_comb begin
    if (idx_q == 2'd0) begin
      out_word_o = ctrl;
    end else if (idx_q <= head_i.count) begin
      out_word_o = head_i.words[idx_q - 2'd1];
    end else begin
      out_word_o = NopWord;
    end
  end

  assign idx_d = accept ? idx_q + 2'd1 : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

[design/instruction_bundle_packer_core.sv]
// Order: a closing instruction's bundle is written into the queue; its
// control word shows once it heads the queue, then the single-word output
// port gives one word per cycle while out_ready_i is high, four words per
// bundle for up to 3 instructions; a two-bundle queue decouples the sides.
// Reset: asynchronous, active low; clears pending count, queue and word index.
// ----------------------------------------------------------------------------
// instruction_bundle_packer_core
// Packs shader instructions into four-word bundles with a control word.
// ----------------------------------------------------------------------------
module instruction_bundle_packer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ibp_pkg::WordW-1:0]   instr_word_i,
  input  logic [ibp_pkg::ReuseW-1:0]  instr_reuse_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ibp_pkg::WordW-1:0]   out_word_o,
  output logic                        out_last_o,
  output logic                        program_end_o
);
  import ibp_pkg::*;

  bundle_req_t push;
  bundle_t     head;
  logic        q_full, q_empty, pop;

  ibp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .instr_word_i (instr_word_i),
    .instr_reuse_i(instr_reuse_i),
    .is_last_i    (is_last_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  ibp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (head)
  );

  ibp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .out_last_o   (out_last_o),
    .program_end_o(program_end_o)
  );

endmodule
